FILE: hdl/bcdclk_pkg.sv
// Shared types, operation codes and the seven-segment table of the BCD clock.
package bcdclk_pkg;

   // Operation codes carried in the low bits of the request beat.
   typedef enum logic [2:0] {
      OP_NONE        = 3'd0,
      OP_TICK        = 3'd1,
      OP_TOGGLE_SET  = 3'd2,
      OP_CURSOR_SEC  = 3'd3,
      OP_CURSOR_HOUR = 3'd4,
      OP_DIGIT_UP    = 3'd5,
      OP_DIGIT_DOWN  = 3'd6
   } op_type;

   // Digit positions, hour tens first.
   typedef enum logic [2:0] {
      POS_HOUR_TENS   = 3'd0,
      POS_HOUR_UNITS  = 3'd1,
      POS_MIN_TENS    = 3'd2,
      POS_MIN_UNITS   = 3'd3,
      POS_SEC_TENS    = 3'd4,
      POS_SEC_UNITS   = 3'd5
   } pos_type;

   typedef struct packed {
      logic [3:0] second_units;
      logic [2:0] second_tens;
      logic [3:0] minute_units;
      logic [2:0] minute_tens;
      logic [3:0] hour_units;
      logic [1:0] hour_tens;
   } time_type;

   localparam logic [7:0] TICKS_RESET = 8'd16;
   localparam logic [7:0] SEG_DP      = 8'h80;

   // Segment pattern of one BCD digit, bits 6..0 are g..a.
   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

FILE: hdl/bcd_clock_with_set_keys.sv
// Top level of the 24-hour BCD clock with set keys.
//
// Usage: each request beat carries one operation (none, tick, toggle set
// mode, cursor moves, digit up or down) and a scan position. Every request
// beat yields exactly one response beat with all six time digits, the set
// mode flag, the edit cursor and the seven-segment pattern of the scanned
// digit, all taken after the operation has been applied.
// In run mode a prescaler counts tick operations and the time advances one
// second each time it reaches ticks_per_second (csr_wdata on csr_we; reset
// value 16). In set mode the clock is halted and the keys edit the digit
// under the cursor.
// A request beat is captured in an input register; when it is processed,
// the state update and the response register load happen together. One
// beat is accepted every cycle while the response side keeps up; the
// single-pass state update sets that figure.
// When the receiver stalls, the response register holds its beat and the
// input register holds the next one; req_tready drops only when both are
// full. Reset clears both registers, the time to 00:00:00, run mode,
// cursor on seconds units and the prescaler, and restores the register.
module bcd_clock_with_set_keys (
   input  logic        clock,
   input  logic        reset,
   // Request: [2:0] operation, [5:3] scan_position, [7:6] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Response: [1:0] hour_tens, [5:2] hour_units, [8:6] minute_tens,
   // [12:9] minute_units, [15:13] second_tens, [19:16] second_units,
   // [20] set_mode, [23:21] cursor, [31:24] segments.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_op_ff, in_op_in;
   logic [2:0] in_scan_ff, in_scan_in;

   // Clock state.
   bcdclk_pkg::time_type time_ff, time_in;
   logic       editing_ff, editing_in;
   logic [2:0] cursor_ff, cursor_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] tps_ff, tps_in;

   // Response register.
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;

   logic       advance;
   logic [7:0] tick_sum;
   logic [3:0] scan_digit;
   logic [7:0] seg;

   // One second forward with rollover, including from set hours 24..29.
   function automatic bcdclk_pkg::time_type next_second(input bcdclk_pkg::time_type t);
      bcdclk_pkg::time_type r;
      r = t;
      if (t.second_units < 4'd9) begin
         r.second_units = t.second_units + 4'd1;
      end else begin
         r.second_units = 4'd0;
         if (t.second_tens < 3'd5) begin
            r.second_tens = t.second_tens + 3'd1;
         end else begin
            r.second_tens = 3'd0;
            if (t.minute_units < 4'd9) begin
               r.minute_units = t.minute_units + 4'd1;
            end else begin
               r.minute_units = 4'd0;
               if (t.minute_tens < 3'd5) begin
                  r.minute_tens = t.minute_tens + 3'd1;
               end else begin
                  r.minute_tens = 3'd0;
                  if (t.hour_tens >= 2'd2) begin
                     if (t.hour_units >= 4'd3) begin
                        r.hour_units = 4'd0;
                        r.hour_tens  = 2'd0;
                     end else begin
                        r.hour_units = t.hour_units + 4'd1;
                     end
                  end else if (t.hour_units < 4'd9) begin
                     r.hour_units = t.hour_units + 4'd1;
                  end else begin
                     r.hour_units = 4'd0;
                     r.hour_tens  = t.hour_tens + 2'd1;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // Raise (up) or lower (not up) the digit at one position.
   function automatic bcdclk_pkg::time_type edit_digit(input bcdclk_pkg::time_type t,
                                                        input logic [2:0] pos,
                                                        input logic up);
      bcdclk_pkg::time_type r;
      logic [3:0] d;
      logic [3:0] limit;
      logic [3:0] nd;
      r = t;
      unique case (bcdclk_pkg::pos_type'(pos))
         bcdclk_pkg::POS_HOUR_TENS: begin
            d = {2'b00, t.hour_tens};
            limit = 4'd2;
         end
         bcdclk_pkg::POS_HOUR_UNITS: begin
            d = t.hour_units;
            limit = (t.hour_tens == 2'd2) ? 4'd3 : 4'd9;
         end
         bcdclk_pkg::POS_MIN_TENS: begin
            d = {1'b0, t.minute_tens};
            limit = 4'd5;
         end
         bcdclk_pkg::POS_MIN_UNITS: begin
            d = t.minute_units;
            limit = 4'd9;
         end
         bcdclk_pkg::POS_SEC_TENS: begin
            d = {1'b0, t.second_tens};
            limit = 4'd5;
         end
         default: begin
            d = t.second_units;
            limit = 4'd9;
         end
      endcase
      if (up) begin
         nd = (d < limit) ? d + 4'd1 : 4'd0;
      end else begin
         nd = (d > 4'd0) ? d - 4'd1 : 4'd0;
      end
      unique case (bcdclk_pkg::pos_type'(pos))
         bcdclk_pkg::POS_HOUR_TENS:  r.hour_tens    = nd[1:0];
         bcdclk_pkg::POS_HOUR_UNITS: r.hour_units   = nd;
         bcdclk_pkg::POS_MIN_TENS:   r.minute_tens  = nd[2:0];
         bcdclk_pkg::POS_MIN_UNITS:  r.minute_units = nd;
         bcdclk_pkg::POS_SEC_TENS:   r.second_tens  = nd[2:0];
         default:                    r.second_units = nd;
      endcase
      return r;
   endfunction

   // The pending request is processed when the response register is free
   // or is handing its beat over in this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign tick_sum = tick_count_ff + 8'd1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_scan_in  = in_scan_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_op_in    = req_tdata[2:0];
         in_scan_in  = req_tdata[5:3];
      end
   end

   always_comb begin
      time_in       = time_ff;
      editing_in    = editing_ff;
      cursor_in     = cursor_ff;
      tick_count_in = tick_count_ff;
      unique case (bcdclk_pkg::op_type'(in_op_ff))
         bcdclk_pkg::OP_TICK: begin
            // The prescaler runs in both modes; only run mode moves the time.
            if (tick_sum >= tps_ff) begin
               tick_count_in = 8'd0;
               if (!editing_ff) begin
                  time_in = next_second(time_ff);
               end
            end else begin
               tick_count_in = tick_sum;
            end
         end
         bcdclk_pkg::OP_TOGGLE_SET: begin
            editing_in = !editing_ff;
            if (!editing_ff) begin
               cursor_in = 3'(bcdclk_pkg::POS_SEC_UNITS);
            end
         end
         bcdclk_pkg::OP_CURSOR_SEC: begin
            if (editing_ff && cursor_ff < 3'(bcdclk_pkg::POS_SEC_UNITS)) begin
               cursor_in = cursor_ff + 3'd1;
            end
         end
         bcdclk_pkg::OP_CURSOR_HOUR: begin
            if (editing_ff && cursor_ff > 3'(bcdclk_pkg::POS_HOUR_TENS)) begin
               cursor_in = cursor_ff - 3'd1;
            end
         end
         bcdclk_pkg::OP_DIGIT_UP: begin
            if (editing_ff) begin
               time_in = edit_digit(time_ff, cursor_ff, 1'b1);
            end
         end
         bcdclk_pkg::OP_DIGIT_DOWN: begin
            if (editing_ff) begin
               time_in = edit_digit(time_ff, cursor_ff, 1'b0);
            end
         end
         default: begin
         end
      endcase
   end

   // Scanned digit comes from the updated time.
   always_comb begin
      unique case (in_scan_ff)
         3'(bcdclk_pkg::POS_HOUR_TENS):  scan_digit = {2'b00, time_in.hour_tens};
         3'(bcdclk_pkg::POS_HOUR_UNITS): scan_digit = time_in.hour_units;
         3'(bcdclk_pkg::POS_MIN_TENS):   scan_digit = {1'b0, time_in.minute_tens};
         3'(bcdclk_pkg::POS_MIN_UNITS):  scan_digit = time_in.minute_units;
         3'(bcdclk_pkg::POS_SEC_TENS):   scan_digit = {1'b0, time_in.second_tens};
         3'(bcdclk_pkg::POS_SEC_UNITS):  scan_digit = time_in.second_units;
         default:                        scan_digit = 4'd0;
      endcase
      if (in_scan_ff > 3'(bcdclk_pkg::POS_SEC_UNITS)) begin
         // Positions past the last digit are blank.
         seg = 8'h00;
      end else if (in_scan_ff == 3'(bcdclk_pkg::POS_HOUR_UNITS) ||
                   in_scan_ff == 3'(bcdclk_pkg::POS_MIN_UNITS)) begin
         // The decimal point separates hours, minutes and seconds.
         seg = bcdclk_pkg::seg_of(scan_digit) | bcdclk_pkg::SEG_DP;
      end else begin
         seg = bcdclk_pkg::seg_of(scan_digit);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = {seg, cursor_in, editing_in,
                         time_in.second_units, time_in.second_tens,
                         time_in.minute_units, time_in.minute_tens,
                         time_in.hour_units, time_in.hour_tens};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign tps_in = csr_we ? csr_wdata : tps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         time_ff       <= '0;
         editing_ff    <= 1'b0;
         cursor_ff     <= 3'(bcdclk_pkg::POS_SEC_UNITS);
         tick_count_ff <= 8'd0;
         tps_ff        <= bcdclk_pkg::TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         tps_ff       <= tps_in;
         if (advance) begin
            time_ff       <= time_in;
            editing_ff    <= editing_in;
            cursor_ff     <= cursor_in;
            tick_count_ff <= tick_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_scan_ff  <= in_scan_in;
      out_data_ff <= out_data_in;
   end

endmodule

FILE: hdl/bcdclk_check.sv
// Port-level checks of the BCD clock and their binding to the top level.
module bcdclk_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled response beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // No response beat appears right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response beat present after reset");

   // Hour tens never exceeds two.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("hour tens out of range");

   // The cursor stays on one of the six digits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] != 3'd6 && rsp_tdata[23:21] != 3'd7)
      else $error("cursor out of range");

   // With a free response side the block always takes a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while response side empty");

endmodule

bind bcd_clock_with_set_keys bcdclk_check u_bcdclk_check (.*);

FILE: verif/bcd_clock_with_set_keys_test.sv
// Self-checking testbench of the BCD clock with set keys, with its own time-keeping predictor.
module bcd_clock_with_set_keys_test;

   // Operation code 7 is unused: the block must leave its state alone.
   localparam logic [2:0] OP_RESERVED = 3'd7;
   // Scan positions past the six digits return a blank pattern.
   localparam logic [2:0] BLANK_SCAN_LOW  = 3'd6;
   localparam logic [2:0] BLANK_SCAN_HIGH = 3'd7;
   // Receiver hold-off that fills the two internal registers, and the watchdog limit.
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 3000;
   // Operations generated per register setting.
   localparam int PHASE_ITEMS = 150;
   // Segment font of the digits 0 to 9, bits 6..0 are g..a.
   localparam logic [7:0] SEGMENT_FONT [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   // Full state of the clock as the predictor sees it, the prescaler rate included.
   typedef struct packed {
      logic [0:5][3:0] digit;
      logic            editing;
      logic [2:0]      cursor;
      logic [7:0]      prescale;
      logic [7:0]      rate;
   } clock_state_type;

   // One response beat, laid out as on rsp_tdata.
   typedef struct packed {
      logic [7:0]           segments;
      logic [2:0]           cursor;
      logic                 set_mode;
      bcdclk_pkg::time_type clock_time;
   } readout_type;

   // One request beat before packing.
   typedef struct packed {
      logic [2:0] scan;
      logic [2:0] op;
   } key_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;     // [2:0] operation, [5:3] scan_position, [7:6] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;             // hour_tens .. segments, see readout_type
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;

   // The live state follows accepted beats; the plan state follows generated ones.
   clock_state_type live;
   clock_state_type plan;
   key_beat_type    backlog [$];
   readout_type     due_readouts [$];
   readout_type     want;
   readout_type     got;
   int              emitted;
   int              mismatch_count = 0;
   int              readouts_seen = 0;
   int              send_hold = 0;
   int              recv_hold = 0;
   int              quiet_cycles = 0;
   bit              long_stall_done = 1'b0;
   // While calm is set, neither side inserts random gaps.
   bit              calm = 1'b0;

   bcd_clock_with_set_keys uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to a clock state: prescaler, time advance and the set keys.
   function automatic clock_state_type step_clock(clock_state_type s, logic [2:0] op);
      int         p;
      int         ht;
      int         hu;
      logic [3:0] ceiling;
      logic [3:0] top;
      bit         carry;
      ht = bcdclk_pkg::POS_HOUR_TENS;
      hu = bcdclk_pkg::POS_HOUR_UNITS;
      p = (s.cursor > bcdclk_pkg::POS_SEC_UNITS) ? bcdclk_pkg::POS_SEC_UNITS : s.cursor;
      case (op)
         bcdclk_pkg::OP_TICK: begin
            // The prescaler counts in both modes; the time only moves in run mode.
            s.prescale = s.prescale + 8'd1;
            if (s.prescale >= s.rate) begin
               s.prescale = 8'd0;
               if (!s.editing) begin
                  // Seconds and minutes: units wrap after 9, tens after 5.
                  carry = 1'b1;
                  for (int k = bcdclk_pkg::POS_SEC_UNITS;
                       k >= bcdclk_pkg::POS_MIN_TENS && carry; k--) begin
                     top = (k % 2) ? 4'd9 : 4'd5;
                     if (s.digit[k] < top) begin
                        s.digit[k] = s.digit[k] + 4'd1;
                        carry = 1'b0;
                     end else begin
                        s.digit[k] = 4'd0;
                     end
                  end
                  // Hours in the twenties roll to midnight once the units reach 3 or more.
                  if (carry) begin
                     if (s.digit[ht] >= 4'd2) begin
                        if (s.digit[hu] >= 4'd3) begin
                           s.digit[hu] = 4'd0;
                           s.digit[ht] = 4'd0;
                        end else begin
                           s.digit[hu] = s.digit[hu] + 4'd1;
                        end
                     end else if (s.digit[hu] < 4'd9) begin
                        s.digit[hu] = s.digit[hu] + 4'd1;
                     end else begin
                        s.digit[hu] = 4'd0;
                        s.digit[ht] = s.digit[ht] + 4'd1;
                     end
                  end
               end
            end
         end
         bcdclk_pkg::OP_TOGGLE_SET: begin
            if (s.editing) begin
               s.editing = 1'b0;
            end else begin
               s.editing = 1'b1;
               s.cursor = bcdclk_pkg::POS_SEC_UNITS;
            end
         end
         bcdclk_pkg::OP_CURSOR_SEC: begin
            if (s.editing && s.cursor < bcdclk_pkg::POS_SEC_UNITS) s.cursor = s.cursor + 3'd1;
         end
         bcdclk_pkg::OP_CURSOR_HOUR: begin
            if (s.editing && s.cursor > bcdclk_pkg::POS_HOUR_TENS) s.cursor = s.cursor - 3'd1;
         end
         bcdclk_pkg::OP_DIGIT_UP: begin
            if (s.editing) begin
               case (p)
                  bcdclk_pkg::POS_HOUR_TENS:  ceiling = 4'd2;
                  bcdclk_pkg::POS_HOUR_UNITS: ceiling = (s.digit[ht] == 4'd2) ? 4'd3 : 4'd9;
                  bcdclk_pkg::POS_MIN_TENS,
                  bcdclk_pkg::POS_SEC_TENS:   ceiling = 4'd5;
                  default:                    ceiling = 4'd9;
               endcase
               s.digit[p] = (s.digit[p] < ceiling) ? s.digit[p] + 4'd1 : 4'd0;
            end
         end
         bcdclk_pkg::OP_DIGIT_DOWN: begin
            if (s.editing && s.digit[p] != 4'd0) s.digit[p] = s.digit[p] - 4'd1;
         end
         default: begin
         end
      endcase
      return s;
   endfunction

   // What the display shows for a state and a scan position.
   function automatic readout_type readout(clock_state_type s, logic [2:0] scan);
      readout_type r;
      logic [3:0]  d;
      r.clock_time.hour_tens    = s.digit[bcdclk_pkg::POS_HOUR_TENS][1:0];
      r.clock_time.hour_units   = s.digit[bcdclk_pkg::POS_HOUR_UNITS];
      r.clock_time.minute_tens  = s.digit[bcdclk_pkg::POS_MIN_TENS][2:0];
      r.clock_time.minute_units = s.digit[bcdclk_pkg::POS_MIN_UNITS];
      r.clock_time.second_tens  = s.digit[bcdclk_pkg::POS_SEC_TENS][2:0];
      r.clock_time.second_units = s.digit[bcdclk_pkg::POS_SEC_UNITS];
      r.set_mode = s.editing;
      r.cursor   = s.cursor;
      r.segments = 8'h00;
      if (scan <= bcdclk_pkg::POS_SEC_UNITS) begin
         d = s.digit[scan];
         if (d <= 4'd9) r.segments = SEGMENT_FONT[d];
         // The decimal point separates hours from minutes and minutes from seconds.
         if (scan == bcdclk_pkg::POS_HOUR_UNITS || scan == bcdclk_pkg::POS_MIN_UNITS)
            r.segments = r.segments | bcdclk_pkg::SEG_DP;
      end
      return r;
   endfunction

   // Gap length for either side: mostly none, sometimes short, now and then long.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   // Scan positions lean toward the six digits, with some blanks.
   function automatic logic [2:0] pick_scan();
      if ($urandom_range(7) == 0) return 3'($urandom_range(BLANK_SCAN_HIGH, BLANK_SCAN_LOW));
      return 3'($urandom_range(bcdclk_pkg::POS_SEC_UNITS, bcdclk_pkg::POS_HOUR_TENS));
   endfunction

   task automatic check_field(string name, logic [7:0] expected_value, logic [7:0] actual_value);
      if (expected_value !== actual_value) begin
         if (mismatch_count < 200)
            $display("%0t: %s expected %0d, actual %0d", $time, name, expected_value, actual_value);
         mismatch_count++;
      end
   endtask

   // Queues one operation and keeps the plan state in step with it.
   task automatic emit(logic [2:0] op, logic [2:0] scan);
      key_beat_type b;
      b.op = op;
      b.scan = scan;
      backlog.push_back(b);
      plan = step_clock(plan, op);
      emitted++;
   endtask

   // Moves the cursor to a digit and keys it to a target. Going up may wrap around,
   // so the target has to be within the digit's range at that point.
   task automatic steer(int p, logic [3:0] target);
      bit upward;
      while (plan.cursor != p)
         emit(plan.cursor > p ? bcdclk_pkg::OP_CURSOR_HOUR : bcdclk_pkg::OP_CURSOR_SEC,
              pick_scan());
      upward = (plan.digit[p] < target) || ($urandom_range(3) == 0);
      while (plan.digit[p] != target)
         emit(upward ? bcdclk_pkg::OP_DIGIT_UP : bcdclk_pkg::OP_DIGIT_DOWN, pick_scan());
   endtask

   // Sets a time, mostly close to a rollover, then runs the clock on from there.
   task automatic set_and_run();
      logic [3:0] goal [6];
      int         ticks;
      goal[bcdclk_pkg::POS_HOUR_TENS]  = 4'($urandom_range(2));
      goal[bcdclk_pkg::POS_HOUR_UNITS] = 4'($urandom_range(9));
      if (goal[bcdclk_pkg::POS_HOUR_TENS] == 4'd2 && $urandom_range(2) == 0)
         goal[bcdclk_pkg::POS_HOUR_UNITS] = 4'd3;
      if ($urandom_range(9) < 7) begin
         goal[bcdclk_pkg::POS_MIN_TENS]  = 4'd5;
         goal[bcdclk_pkg::POS_MIN_UNITS] = 4'd9;
         goal[bcdclk_pkg::POS_SEC_TENS]  = 4'd5;
         goal[bcdclk_pkg::POS_SEC_UNITS] = 4'($urandom_range(9, 5));
      end else begin
         goal[bcdclk_pkg::POS_MIN_TENS]  = 4'($urandom_range(5));
         goal[bcdclk_pkg::POS_MIN_UNITS] = 4'($urandom_range(9));
         goal[bcdclk_pkg::POS_SEC_TENS]  = 4'($urandom_range(5));
         goal[bcdclk_pkg::POS_SEC_UNITS] = 4'($urandom_range(9));
      end
      if (!plan.editing) emit(bcdclk_pkg::OP_TOGGLE_SET, pick_scan());
      // Hour tens go to zero first so that every hour unit value can be keyed in;
      // raising the tens last gives hours from 24 to 29 as well.
      steer(bcdclk_pkg::POS_HOUR_TENS, 4'd0);
      for (int k = bcdclk_pkg::POS_HOUR_UNITS; k <= bcdclk_pkg::POS_SEC_UNITS; k++)
         steer(k, goal[k]);
      steer(bcdclk_pkg::POS_HOUR_TENS, goal[bcdclk_pkg::POS_HOUR_TENS]);
      emit(bcdclk_pkg::OP_TOGGLE_SET, pick_scan());
      ticks = ((plan.rate == 8'd0) ? 1 : plan.rate) * $urandom_range(8, 1) + $urandom_range(2);
      if (ticks > 300) ticks = 300;
      repeat (ticks) emit(bcdclk_pkg::OP_TICK, pick_scan());
   endtask

   // Random key presses in set mode, leaving it about half of the time.
   task automatic edit_session();
      int r;
      if (!plan.editing) emit(bcdclk_pkg::OP_TOGGLE_SET, pick_scan());
      repeat ($urandom_range(20, 5)) begin
         r = $urandom_range(9);
         if (r < 2)      emit(bcdclk_pkg::OP_CURSOR_SEC, pick_scan());
         else if (r < 4) emit(bcdclk_pkg::OP_CURSOR_HOUR, pick_scan());
         else if (r < 7) emit(bcdclk_pkg::OP_DIGIT_UP, pick_scan());
         else if (r < 9) emit(bcdclk_pkg::OP_DIGIT_DOWN, pick_scan());
         else            emit(bcdclk_pkg::OP_TICK, pick_scan());
      end
      if ($urandom_range(1) == 0) emit(bcdclk_pkg::OP_TOGGLE_SET, pick_scan());
   endtask

   // Ticks in run mode with some stray operations among them.
   task automatic run_ticks();
      if (plan.editing) emit(bcdclk_pkg::OP_TOGGLE_SET, pick_scan());
      repeat ($urandom_range(60, 10)) begin
         if ($urandom_range(99) < 85) emit(bcdclk_pkg::OP_TICK, pick_scan());
         else emit(3'($urandom_range(OP_RESERVED)), pick_scan());
      end
   endtask

   task automatic fill_phase();
      int r;
      emitted = 0;
      while (emitted < PHASE_ITEMS) begin
         r = $urandom_range(99);
         if (r < 40)      set_and_run();
         else if (r < 70) edit_session();
         else if (r < 90) run_ticks();
         else repeat ($urandom_range(15, 5)) emit(3'($urandom_range(OP_RESERVED)), pick_scan());
      end
   endtask

   // Waits until every queued beat has been sent and every response has come back.
   task automatic drain();
      while (backlog.size() != 0 || due_readouts.size() != 0) @(negedge clock);
   endtask

   // The rate register is written only while the block is idle.
   task automatic write_rate(logic [7:0] value);
      drain();
      repeat (4) @(negedge clock);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      live.rate = value;
      plan = live;
      @(negedge clock);
   endtask

   // Driver: offers the oldest queued beat, holds it until taken, and predicts the
   // response of every accepted beat from the live state.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            live = step_clock(live, req_tdata[2:0]);
            due_readouts.push_back(readout(live, req_tdata[5:3]));
            void'(backlog.pop_front());
            send_hold = idle_gap();
            // Now and then switch to or from a stretch with no gaps on either side.
            if ($urandom_range(63) == 0) calm = !calm;
         end
         if (req_tvalid && !req_tready) begin
            // The offered beat stays on the bus until it is accepted.
         end else if (send_hold > 0) begin
            send_hold--;
            req_tvalid <= 1'b0;
         end else if (backlog.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, backlog[0].scan, backlog[0].op};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response beat field by field against the oldest prediction
   // and drives rsp_tready with random stalls, one of them long enough to back up
   // the input side while the driver still has beats to offer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = readout_type'(rsp_tdata);
            if (due_readouts.size() == 0) begin
               if (mismatch_count < 200)
                  $display("%0t: response with no expectation waiting, expected none, actual %h",
                           $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = due_readouts.pop_front();
               check_field("hour_tens", want.clock_time.hour_tens, got.clock_time.hour_tens);
               check_field("hour_units", want.clock_time.hour_units, got.clock_time.hour_units);
               check_field("minute_tens", want.clock_time.minute_tens, got.clock_time.minute_tens);
               check_field("minute_units", want.clock_time.minute_units,
                           got.clock_time.minute_units);
               check_field("second_tens", want.clock_time.second_tens, got.clock_time.second_tens);
               check_field("second_units", want.clock_time.second_units,
                           got.clock_time.second_units);
               check_field("set_mode", want.set_mode, got.set_mode);
               check_field("cursor", want.cursor, got.cursor);
               check_field("segments", want.segments, got.segments);
            end
            readouts_seen++;
         end
         if (!long_stall_done && readouts_seen >= 400 && backlog.size() > 8) begin
            long_stall_done = 1'b1;
            recv_hold = LONG_HOLD;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_hold = idle_gap();
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // Stimulus: a directed opening and a random phase at the reset rate, then
   // one more random phase after each idle write of a new rate. The rates include
   // both extremes and zero, which advances the time on every tick.
   initial begin
      logic [7:0] rate_list [5];
      rate_list = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd0};
      rate_list[4] = 8'($urandom_range(254, 3));
      live = '0;
      live.cursor = bcdclk_pkg::POS_SEC_UNITS;
      live.rate = bcdclk_pkg::TICKS_RESET;
      plan = live;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: every operation, every scan position and the edit limits.
      emit(bcdclk_pkg::OP_NONE, bcdclk_pkg::POS_HOUR_TENS);
      emit(bcdclk_pkg::OP_TICK, BLANK_SCAN_HIGH);
      emit(bcdclk_pkg::OP_TOGGLE_SET, BLANK_SCAN_LOW);
      // Lowering a digit that is already zero leaves it at zero.
      emit(bcdclk_pkg::OP_DIGIT_DOWN, bcdclk_pkg::POS_SEC_UNITS);
      emit(bcdclk_pkg::OP_DIGIT_UP, bcdclk_pkg::POS_SEC_UNITS);
      // The cursor saturates at the seconds units and at the hour tens.
      emit(bcdclk_pkg::OP_CURSOR_SEC, bcdclk_pkg::POS_HOUR_UNITS);
      for (int k = 0; k < 5; k++) emit(bcdclk_pkg::OP_CURSOR_HOUR, 3'(k));
      emit(bcdclk_pkg::OP_CURSOR_HOUR, bcdclk_pkg::POS_MIN_UNITS);
      // Hour tens count 1, 2 and wrap to 0, then go back to 2.
      repeat (3) emit(bcdclk_pkg::OP_DIGIT_UP, bcdclk_pkg::POS_HOUR_TENS);
      repeat (2) emit(bcdclk_pkg::OP_DIGIT_UP, bcdclk_pkg::POS_HOUR_TENS);
      // With the hour tens at 2, the hour units wrap after 3.
      emit(bcdclk_pkg::OP_CURSOR_SEC, bcdclk_pkg::POS_HOUR_UNITS);
      repeat (4) emit(bcdclk_pkg::OP_DIGIT_UP, bcdclk_pkg::POS_HOUR_UNITS);
      emit(bcdclk_pkg::OP_DIGIT_DOWN, bcdclk_pkg::POS_HOUR_UNITS);
      emit(OP_RESERVED, bcdclk_pkg::POS_MIN_TENS);
      // Back in run mode the cursor and digit keys have no effect.
      emit(bcdclk_pkg::OP_TOGGLE_SET, bcdclk_pkg::POS_SEC_TENS);
      emit(bcdclk_pkg::OP_CURSOR_SEC, bcdclk_pkg::POS_HOUR_TENS);
      emit(bcdclk_pkg::OP_DIGIT_UP, bcdclk_pkg::POS_HOUR_UNITS);
      emit(bcdclk_pkg::OP_DIGIT_DOWN, bcdclk_pkg::POS_SEC_UNITS);

      fill_phase();
      foreach (rate_list[k]) begin
         write_rate(rate_list[k]);
         fill_phase();
      end

      drain();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/bcdclk_pkg.sv
hdl/bcd_clock_with_set_keys.sv
hdl/bcdclk_check.sv
verif/bcd_clock_with_set_keys_test.sv
